// File: rtl/mppt_perturb_observe_duty_top_defines.svh
// assertion macros for the mppt perturb-and-observe duty block
`ifndef MPPT_PERTURB_OBSERVE_DUTY_TOP_DEFINES_SVH
`define MPPT_PERTURB_OBSERVE_DUTY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define MPPO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked also while reset is high
`define MPPO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPPO_ASSERT(lbl, prop, msg)
`define MPPO_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/mppo_pkg.sv
// shared types and constants for the mppt perturb-and-observe duty block
package mppo_pkg;

  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned POWER_W = 23;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned MA_W    = 16;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned QUOT_W  = 22;

  localparam logic [DUTY_W-1:0] DUTY_PERIOD = 10'd1000;
  localparam logic [DUTY_W-1:0] DUTY_MIN    = 10'd50;
  localparam logic [DUTY_W-1:0] DUTY_MAX    = 10'd950;
  localparam logic [DUTY_W-1:0] DUTY_RESET  = 10'd500;
  localparam logic [MA_W-1:0]   MA_LIMIT    = 16'd4000;

  // ceil(2^41 / 1000): exact floor division by 1000 for magnitudes below 2^31
  localparam logic [MAG_W-1:0] RECIP       = 32'd2199023256;
  localparam int unsigned      RECIP_SHIFT = 41;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DUTY_W-1:0] set_duty;
  } pass_t;

endpackage

// File: rtl/mppo_power.sv
// two-stage power unit: signed product magnitude, then divide by 1000 via reciprocal
module mppo_power
  import mppo_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MV_W-1:0]          in_mv,
  input  logic signed [MA_W-1:0]   in_ma,
  input  pass_t                    in_pass,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [QUOT_W-1:0]        out_quot,
  output logic                     out_neg,
  output pass_t                    out_pass
);

  logic signed [MV_W+MA_W:0] prod;
  logic [MV_W+MA_W:0]        prod_abs;
  logic [2*MAG_W-1:0]        scaled;

  logic               b_valid;
  logic [MAG_W-1:0]   b_mag;
  logic               b_neg;
  pass_t              b_pass;
  logic               b_ready;

  logic               c_valid;
  logic [QUOT_W-1:0]  c_quot;
  logic               c_neg;
  pass_t              c_pass;
  logic               c_ready;

  assign prod     = $signed({1'b0, in_mv}) * in_ma;
  assign prod_abs = prod[MV_W+MA_W] ? (MV_W+MA_W+1)'(-prod) : prod;

  assign scaled = {{MAG_W{1'b0}}, b_mag} * {{MAG_W{1'b0}}, RECIP};

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign in_ready = b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (b_ready) b_valid <= in_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_mag  <= prod_abs[MAG_W-1:0];
      b_neg  <= prod[MV_W+MA_W];
      b_pass <= in_pass;
    end
    if (c_ready) begin
      c_quot <= scaled[RECIP_SHIFT +: QUOT_W];
      c_neg  <= b_neg;
      c_pass <= b_pass;
    end
  end

  assign out_valid = c_valid;
  assign out_quot  = c_quot;
  assign out_neg   = c_neg;
  assign out_pass  = c_pass;

endmodule

// File: rtl/mppo_track.sv
// tracker state update: direction, duty step and clamp, stored power, result register
module mppo_track
  import mppo_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [QUOT_W-1:0]         in_quot,
  input  logic                      in_neg,
  input  pass_t                     in_pass,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DUTY_W-1:0]         out_duty,
  output logic signed [POWER_W-1:0] out_power,
  output logic                      out_up
);

  logic                      tracking_enable;
  logic [DUTY_W-1:0]         duty_reg;
  logic                      step_dir_up;
  logic signed [POWER_W-1:0] prior_power;
  logic signed [POWER_W-1:0] power_out;

  logic [DUTY_W-1:0]         duty_reg_next;
  logic                      step_dir_up_next;
  logic signed [POWER_W-1:0] prior_power_next;
  logic signed [POWER_W-1:0] power_out_next;

  logic [POWER_W-1:0]        pw_mag;
  logic signed [POWER_W-1:0] pw;
  logic                      dir_new;
  logic signed [DUTY_W+1:0]  stepped;
  logic                      accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign pw_mag  = {1'b0, in_quot};
  assign pw      = in_neg ? $signed(-pw_mag) : $signed(pw_mag);
  // equal power counts as no rise
  assign dir_new = (pw > prior_power) ? step_dir_up : !step_dir_up;
  assign stepped = $signed({2'b00, duty_reg}) + (dir_new ? 12'sd1 : -12'sd1);

  always_comb begin
    duty_reg_next    = duty_reg;
    step_dir_up_next = step_dir_up;
    prior_power_next = prior_power;
    power_out_next   = '0;
    case (in_pass.mode)
      MODE_SET: begin
        duty_reg_next = in_pass.set_duty;
      end
      MODE_TICK: begin
        if (tracking_enable) begin
          step_dir_up_next = dir_new;
          if (stepped < $signed({2'b00, DUTY_MIN})) begin
            duty_reg_next = DUTY_MIN;
          end else if (stepped > $signed({2'b00, DUTY_MAX})) begin
            duty_reg_next = DUTY_MAX;
          end else begin
            duty_reg_next = stepped[DUTY_W-1:0];
          end
          prior_power_next = pw;
          power_out_next   = pw;
        end
      end
      default: begin
        duty_reg_next = duty_reg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b0;
      duty_reg        <= DUTY_RESET;
      step_dir_up     <= 1'b1;
      prior_power     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) tracking_enable <= cfg_wr_data;
      if (in_ready) out_valid <= in_valid;
      if (accept) begin
        duty_reg    <= duty_reg_next;
        step_dir_up <= step_dir_up_next;
        prior_power <= prior_power_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) power_out <= power_out_next;
  end

  // state only moves when a new result replaces the held one
  assign out_duty  = duty_reg;
  assign out_power = power_out;
  assign out_up    = step_dir_up;

endmodule

// File: rtl/mppt_perturb_observe_duty_top.sv
// Perturb-and-observe MPPT duty tracker. Each input beat is either a tracking
// tick (tuser = 0: solar mV and signed charge mA) or a direct set (tuser = 1:
// target mA, clamped to 4000, duty = mA/4). One result beat per input beat
// carries the duty count, the tick's power in mW (zero for sets and disabled
// ticks) and the step direction. The block takes one beat per cycle while no
// stage stalls on back-pressure, and carries each beat through four
// registers: input register, signed product stage, reciprocal-multiply stage
// for the divide by 1000, and the state update that feeds the output register.
// Each stage holds its item while the next one is full, so input stalls only
// when all four are occupied.
// tracking_enable is written through cfg_wr_en/cfg_wr_data and resets to 0.
`include "mppt_perturb_observe_duty_top_defines.svh"

module mppt_perturb_observe_duty_top
  import mppo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // tracking_enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,    // solar_mv[15:0], charge_ma[31:16], target_ma[47:32]
  input  logic        s_axis_tuser,    // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata     // duty_count[9:0], power_mw[32:10], moving_up[33], zero
);

  logic [MA_W-1:0]   target_lim;
  pass_t             in_pass;

  logic                    a_valid;
  logic                    a_ready;
  logic [MV_W-1:0]         a_mv;
  logic signed [MA_W-1:0]  a_ma;
  pass_t                   a_pass;

  logic                    p_in_ready;
  logic                    p_out_valid;
  logic [QUOT_W-1:0]       p_quot;
  logic                    p_neg;
  pass_t                   p_pass;
  logic                    t_in_ready;

  logic [DUTY_W-1:0]         duty_count;
  logic signed [POWER_W-1:0] power_mw;
  logic                      moving_up;
  logic                      stages_full;

  assign target_lim       = (s_axis_tdata[47:32] > MA_LIMIT) ? MA_LIMIT : s_axis_tdata[47:32];
  assign in_pass.mode     = s_axis_tuser;
  assign in_pass.set_duty = target_lim[DUTY_W+1:2];

  assign a_ready       = !a_valid || p_in_ready;
  assign s_axis_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_mv   <= s_axis_tdata[15:0];
      a_ma   <= s_axis_tdata[31:16];
      a_pass <= in_pass;
    end
  end

  mppo_power u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (p_in_ready),
    .in_mv     (a_mv),
    .in_ma     (a_ma),
    .in_pass   (a_pass),
    .out_valid (p_out_valid),
    .out_ready (t_in_ready),
    .out_quot  (p_quot),
    .out_neg   (p_neg),
    .out_pass  (p_pass)
  );

  mppo_track u_track (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (p_out_valid),
    .in_ready    (t_in_ready),
    .in_quot     (p_quot),
    .in_neg      (p_neg),
    .in_pass     (p_pass),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_duty    (duty_count),
    .out_power   (power_mw),
    .out_up      (moving_up)
  );

  assign m_axis_tdata = {6'b000000, moving_up, power_mw, duty_count};

  assign stages_full = a_valid && p_out_valid && m_axis_tvalid;

  `MPPO_ASSERT_RST(a_reset_clears_out, rst |=> !m_axis_tvalid, "result valid after reset")
  `MPPO_ASSERT(a_duty_range, m_axis_tvalid |-> (duty_count <= DUTY_PERIOD), "duty too large")
  `MPPO_ASSERT(a_stall_full, !s_axis_tready |-> stages_full, "input stalled with a free stage")

endmodule
